// File: src/lqrb_pkg.sv
// ----------------------------------------------------------------------------
// lqrb_pkg
// Shared types and constants for the link quality report builder.
// ----------------------------------------------------------------------------
package lqrb_pkg;

  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 184;
  localparam int FUNC_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [FUNC_W-1:0] FN_ROUND     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADAPTER   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STREAM    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PROBE_ON  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PROBE_OFF = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 1'b1;

  localparam logic [31:0] INTERVAL_RST   = 32'd1000;
  localparam logic [6:0]  DIV_LOSS_STEPS = 7'd64;
  localparam logic [6:0]  DIV_MEAN_STEPS = 7'd16;
  localparam int          MEAN_PAD       = 48;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DELTA, S_MULA, S_MULB, S_LDL, S_DIVL, S_DIVM, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic delta;
    logic mula;
    logic mulb;
    logic div_loss;
    logic take_loss;
    logic take_mean;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic stream_go;
    logic scan_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: src/lqrb_div.sv
// ----------------------------------------------------------------------------
// lqrb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lqrb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic [6:0]  steps,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dsr_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] shifted, diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[63]};
    diff     = shifted - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done     = !busy_r;
  assign quotient = dvd_r;

endmodule

// File: src/lqrb_ctrl.sv
// ----------------------------------------------------------------------------
// lqrb_ctrl
// Sequencer for one request: table scan, deltas, loss and mean division.
// ----------------------------------------------------------------------------
module lqrb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lqrb_pkg::stat_t st,
  output lqrb_pkg::cmd_t  cmd
);

  lqrb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lqrb_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      lqrb_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (st.stream_go) state_nxt = lqrb_pkg::S_SCAN;
        end
      end
      lqrb_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_nxt = lqrb_pkg::S_DELTA;
      end
      lqrb_pkg::S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = lqrb_pkg::S_MULA;
      end
      lqrb_pkg::S_MULA: begin
        cmd.mula  = 1'b1;
        state_nxt = lqrb_pkg::S_MULB;
      end
      lqrb_pkg::S_MULB: begin
        cmd.mulb  = 1'b1;
        state_nxt = lqrb_pkg::S_LDL;
      end
      lqrb_pkg::S_LDL: begin
        cmd.div_loss = 1'b1;
        state_nxt    = lqrb_pkg::S_DIVL;
      end
      lqrb_pkg::S_DIVL: begin
        if (st.div_done) begin
          cmd.take_loss = 1'b1;
          state_nxt     = lqrb_pkg::S_DIVM;
        end
      end
      lqrb_pkg::S_DIVM: begin
        if (st.div_done) begin
          cmd.take_mean = 1'b1;
          state_nxt     = lqrb_pkg::S_OUT;
        end
      end
      lqrb_pkg::S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = lqrb_pkg::S_IDLE;
        end
      end
      default: state_nxt = lqrb_pkg::S_IDLE;
    endcase
  end

endmodule

// File: src/lqrb_dp.sv
// ----------------------------------------------------------------------------
// lqrb_dp
// Round and probe state, RSSI summary, snapshot table and report register.
// ----------------------------------------------------------------------------
module lqrb_dp #(
  parameter int MAX_STREAMS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lqrb_pkg::FUNC_W-1:0]          in_tuser,
  input  logic [lqrb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 cfg_we,
  input  logic [lqrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lqrb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  lqrb_pkg::cmd_t                       cmd,
  output lqrb_pkg::stat_t                      st,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lqrb_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int AW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_STREAMS - 1);

  // input fields
  logic [63:0] i_tb, i_uni, i_lost;
  logic [7:0]  i_live, i_strm;
  logic        i_elig;
  logic signed [7:0] i_rec, i_avg;
  logic [23:0] i_org;
  logic [31:0] i_ses, i_div;

  assign i_tb   = in_tdata[63:0];
  assign i_live = in_tdata[71:64];
  assign i_elig = in_tdata[72];
  assign i_rec  = in_tdata[80:73];
  assign i_avg  = in_tdata[88:81];
  assign i_org  = in_tdata[112:89];
  assign i_ses  = in_tdata[144:113];
  assign i_strm = in_tdata[152:145];
  assign i_uni  = in_tdata[216:153];
  assign i_lost = in_tdata[280:217];
  assign i_div  = in_tdata[312:281];

  logic [31:0] interval_r;
  logic [15:0] version_r;
  logic [63:0] next_due_r;
  logic        probe_r, open_r;
  logic [31:0] burst_r;
  logic [7:0]  live_r, ewma_n_r;
  logic signed [7:0]  best_r;
  logic signed [15:0] ewma_sum_r;

  // control/config state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= lqrb_pkg::INTERVAL_RST;
      version_r  <= '0;
      next_due_r <= '0;
      probe_r    <= 1'b0;
      burst_r    <= '0;
      open_r     <= 1'b0;
      live_r     <= '0;
      best_r     <= '0;
      ewma_sum_r <= '0;
      ewma_n_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lqrb_pkg::CFG_INTERVAL: interval_r <= cfg_data;
          lqrb_pkg::CFG_VERSION:  version_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (in_tuser)
          lqrb_pkg::FN_ROUND: begin
            if (probe_r ? (burst_r != '0) : (i_tb >= next_due_r)) begin
              open_r     <= 1'b1;
              next_due_r <= i_tb + {32'd0, interval_r};
              live_r     <= i_live;
              best_r     <= '0;
              ewma_sum_r <= '0;
              ewma_n_r   <= '0;
            end else begin
              open_r <= 1'b0;
            end
          end
          lqrb_pkg::FN_ADAPTER: begin
            if (open_r && i_elig && ewma_n_r != 8'hFF) begin
              if (ewma_n_r == '0 || i_rec > best_r) best_r <= i_rec;
              ewma_sum_r <= ewma_sum_r + 16'(i_avg);
              ewma_n_r   <= ewma_n_r + 8'd1;
            end
          end
          lqrb_pkg::FN_PROBE_ON: begin
            probe_r <= 1'b1;
            burst_r <= (i_tb[63:32] != '0) ? '1 : i_tb[31:0];
          end
          lqrb_pkg::FN_PROBE_OFF: begin
            probe_r <= 1'b0;
            burst_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.out_load && probe_r && burst_r != '0) burst_r <= burst_r - 32'd1;
    end
  end

  assign st.stream_go = (in_tuser == lqrb_pkg::FN_STREAM) && open_r && i_elig;

  // latched stream item
  logic [23:0] org_r;
  logic [31:0] ses_r, div_r;
  logic [7:0]  strm_r;
  logic [63:0] uni_r, lost_r;
  logic [63:0] key;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      org_r  <= i_org;
      ses_r  <= i_ses;
      strm_r <= i_strm;
      uni_r  <= i_uni;
      lost_r <= i_lost;
      div_r  <= i_div;
    end
  end

  assign key = {org_r, ses_r, strm_r};

  // snapshot table: {key, unique, lost}
  logic [191:0] mem [MAX_STREAMS];
  logic [191:0] rd_q;
  logic [MAX_STREAMS-1:0] vld_r;
  logic [AW-1:0] sc_r, chk_r, slot_r, free_r, wr_slot;
  logic          sc_act_r, chk_go_r, found_r, has_free_r, wr_en;
  logic [63:0]   pu_r, pl_r;

  assign wr_en   = cmd.delta && (found_r || has_free_r);
  assign wr_slot = found_r ? slot_r : free_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_slot] <= {key, uni_r, lost_r};
    rd_q <= mem[sc_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      sc_act_r <= 1'b0;
      chk_go_r <= 1'b0;
      sc_r     <= '0;
    end else begin
      if (wr_en) vld_r[wr_slot] <= 1'b1;
      if (cmd.accept) begin
        sc_r     <= '0;
        sc_act_r <= st.stream_go;
        chk_go_r <= 1'b0;
      end else if (cmd.scan && sc_act_r) begin
        chk_go_r <= 1'b1;
        if (sc_r == LAST) sc_act_r <= 1'b0;
        else              sc_r <= sc_r + AW'(1);
      end else begin
        chk_go_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      found_r    <= 1'b0;
      has_free_r <= 1'b0;
      pu_r       <= '0;
      pl_r       <= '0;
    end else if (chk_go_r) begin
      if (vld_r[chk_r]) begin
        if (!found_r && rd_q[191:128] == key) begin
          found_r <= 1'b1;
          slot_r  <= chk_r;
          pu_r    <= rd_q[127:64];
          pl_r    <= rd_q[63:0];
        end
      end else if (!has_free_r) begin
        has_free_r <= 1'b1;
        free_r     <= chk_r;
      end
    end
    chk_r <= sc_r;
  end

  assign st.scan_done = chk_go_r && (chk_r == LAST);

  // deltas, loss numerator
  logic [63:0] du_r, dl_r, den_r, num_r;

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      du_r <= uni_r - pu_r;
      dl_r <= lost_r - pl_r;
    end
    if (cmd.mula) begin
      den_r <= du_r + dl_r;
      num_r <= {dl_r[53:0], 10'd0} - {dl_r[59:0], 4'd0};
    end
    if (cmd.mulb) num_r <= num_r - {dl_r[60:0], 3'd0};
  end

  // shared divider
  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic [6:0]  div_n;
  logic        sum_neg;
  logic [15:0] sum_mag;

  assign sum_neg   = ewma_sum_r[15];
  assign sum_mag   = sum_neg ? 16'(-ewma_sum_r) : ewma_sum_r;
  assign div_start = cmd.div_loss || cmd.take_loss;
  assign div_a     = cmd.div_loss ? num_r : {sum_mag, {lqrb_pkg::MEAN_PAD{1'b0}}};
  assign div_b     = cmd.div_loss ? den_r : {56'd0, ewma_n_r};
  assign div_n     = cmd.div_loss ? lqrb_pkg::DIV_LOSS_STEPS : lqrb_pkg::DIV_MEAN_STEPS;

  lqrb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .steps    (div_n),
    .done     (div_done),
    .quotient (div_q)
  );

  assign st.div_done = div_done;

  logic [15:0] loss_r;
  logic [7:0]  mean_r;

  always_ff @(posedge clk) begin
    if (cmd.take_loss) loss_r <= (den_r == '0) ? '0 : div_q[15:0];
    if (cmd.take_mean) begin
      if (ewma_n_r == '0) mean_r <= '0;
      else                mean_r <= sum_neg ? 8'(-div_q[7:0]) : div_q[7:0];
    end
  end

  // report register
  logic        ovld_r;
  logic [lqrb_pkg::OUT_TDATA_W-1:0] odata_r;
  logic [31:0] usat;

  assign usat = (den_r[63:32] != '0) ? '1 : den_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n)              ovld_r <= 1'b0;
    else if (cmd.out_load)   ovld_r <= 1'b1;
    else if (out_tready)     ovld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      odata_r <= {live_r, div_r, usat, loss_r, mean_r, best_r, version_r,
                  strm_r, ses_r, org_r};
  end

  assign st.out_free = !ovld_r || out_tready;
  assign out_tvalid  = ovld_r;
  assign out_tdata   = odata_r;

endmodule

// File: src/link_quality_report_builder_unit.sv
// ----------------------------------------------------------------------------
// link_quality_report_builder_unit
// Paced link-quality reporter: round pacing, RSSI summary, per-stream loss.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  in_      in   tvalid/tready     tuser func, tdata item fields
//  out_     out  tvalid/tready     tdata report fields
//  cfg_     in   we                index, data
//
// Round, adapter and probe requests are applied from the idle state. A stream
// request makes a pass over the snapshot memory, one entry per cycle, then a
// 64-step loss division and a 16-step mean division on one shared bit-serial
// divider, and the next request is taken once its report is loaded. Reset is
// synchronous, active low, and clears all snapshot valid bits at once. A
// waiting report holds in the output register; later requests are taken until
// the next report is ready.
// ----------------------------------------------------------------------------
module link_quality_report_builder_unit #(
  parameter int MAX_STREAMS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // func[2:0]
  input  logic [lqrb_pkg::FUNC_W-1:0]       in_tuser,
  // time_or_budget[63:0] live_count[71:64] eligible[72] rssi_recent[80:73]
  // rssi_average[88:81] origin_id[112:89] session[144:113]
  // stream_number[152:145] unique_total[216:153] lost_total[280:217]
  // path_diversity[312:281], zero fill above
  input  logic [lqrb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // rep_origin[23:0] rep_session[55:24] rep_stream[63:56]
  // rep_table_version[79:64] best_rssi[87:80] mean_rssi[95:88]
  // loss_permille[111:96] unique_plus_lost_delta[143:112] rep_diversity[175:144]
  // live_count[183:176]
  output logic [lqrb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [lqrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lqrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lqrb_pkg::cmd_t  cmd;
  lqrb_pkg::stat_t st;

  lqrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lqrb_dp #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
